>>> src/cers_pkg.sv
package cers_pkg;

	// register map
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MINUTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE_WIDTH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ADVANCE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_OFF_TIME = 8'd3;

	// reset and limit constants
	localparam logic [31:0] TPM_RESET = 32'd75000000;
	localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
	localparam logic [15:0] SAT_16 = 16'hFFFF;

	// divider sizing: one quotient bit per step
	localparam int unsigned DIV_W = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_PROGRAM = 2'd1,
		ACT_HOLD = 2'd2
	} action_t;

	typedef struct packed {
		logic [15:0] edge_time;
		logic rising;
		logic overflow_pending;
		logic [15:0] extension_count;
		logic [15:0] pulse_width;
		logic [15:0] injection_angle;
		logic [31:0] cycle_period;
		logic [31:0] last_end_time;
		logic channel_busy;
	} in_word_t;

	typedef struct packed {
		logic leading_edge;
		logic [31:0] full_timestamp;
		logic [31:0] pulse_period;
		logic [15:0] rpm;
		action_t action;
		logic [15:0] start_time;
		logic [15:0] teeth_seen;
	} out_word_t;

	// scheduling settings handed to the scheduler
	typedef struct packed {
		logic [15:0] min_pulse_width;
		logic [15:0] min_advance;
		logic [15:0] switch_off_time;
	} sched_cfg_t;

	// scheduler result
	typedef struct packed {
		action_t action;
		logic [15:0] start_time;
	} sched_res_t;

endpackage

>>> src/cers_div.sv
module cers_div import cers_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIV_W-1:0] dividend,
	input logic [DIV_W-1:0] divisor,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0] rem_sh;
	logic [DIV_W+1:0] diff;
	logic ge;

	// one restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q, dvd_q[DIV_W-1]};
		diff = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge = ~diff[DIV_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;

endmodule

>>> src/cers_sched.sv
module cers_sched import cers_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input in_word_t word,
	input logic [31:0] stamp,
	input sched_cfg_t cfg,
	output sched_res_t res
);

	logic v_s1;
	logic v_s2;
	logic [15:0] max_after;
	logic inj_s1;
	logic [15:0] adv_s1;
	logic inj_s2;
	logic [15:0] start_s2;
	logic [31:0] sum_a_s2;
	logic [31:0] sum_b_s2;
	logic [31:0] diff;
	sched_res_t res_s3;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// upper clamp: half the cycle period, capped at 16 bits
	assign max_after = (word.cycle_period[31:17] != '0) ? SAT_16 : word.cycle_period[16:1];

	// stage 1: gate and clamp the advance
	always_ff @(posedge clk) begin
		if (start) begin
			inj_s1 <= word.pulse_width > cfg.min_pulse_width;
			if (word.injection_angle > max_after)
				adv_s1 <= max_after;
			else if (word.injection_angle < cfg.min_advance)
				adv_s1 <= cfg.min_advance;
			else
				adv_s1 <= word.injection_angle;
		end
	end

	// stage 2: start time and both sides of the reschedule test
	always_ff @(posedge clk) begin
		if (v_s1) begin
			inj_s2 <= inj_s1;
			start_s2 <= word.edge_time + adv_s1;
			sum_a_s2 <= stamp + {16'd0, adv_s1};
			sum_b_s2 <= word.last_end_time + {16'd0, cfg.switch_off_time};
		end
	end

	assign diff = sum_a_s2 - sum_b_s2;

	// stage 3: decide action
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (!inj_s2) begin
				res_s3.action <= ACT_NONE;
				res_s3.start_time <= '0;
			end else begin
				res_s3.start_time <= start_s2;
				if (!word.channel_busy || (diff > HALF_RANGE))
					res_s3.action <= ACT_PROGRAM;
				else
					res_s3.action <= ACT_HOLD;
			end
		end
	end

	assign res = res_s3;

endmodule

>>> src/crank_edge_rpm_and_injection_scheduler.sv
// Channel  | Signals                          | Word
// ---------+----------------------------------+--------------------------
// input    | in_valid / in_ready / in_data    | in_word_t, one edge
// output   | out_valid / out_ready / out_data | out_word_t, one result
// config   | cfg_we / cfg_index / cfg_data    | 32-bit register write
//
// A rising edge goes from accept to result through extend, launch,
// 32 steps of the restoring divider, done flag and load. A falling
// edge goes from extend straight to load. One edge is in work at a
// time; in_ready is high only while idle. The output register holds a
// finished word while the next edge is accepted; that edge waits in its
// last step until the register frees. Reset clears state and loads
// register defaults.
module crank_edge_rpm_and_injection_scheduler import cers_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_word_t out_data,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXT,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t state_q;
	in_word_t in_q;
	logic [31:0] tpm_q;
	sched_cfg_t scfg_q;
	logic [31:0] prev_q;
	logic [15:0] teeth_q;
	logic [31:0] stamp_q;
	logic [31:0] period_q;
	logic leading_q;
	logic out_valid_q;
	out_word_t out_q;

	logic [15:0] upper;
	logic [31:0] stamp;
	logic launch;
	logic div_done;
	logic [DIV_W-1:0] quotient;
	logic [15:0] rpm;
	sched_res_t sres;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= TPM_RESET;
			scfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_MINUTE: tpm_q <= cfg_data;
				REG_MIN_PULSE_WIDTH: scfg_q.min_pulse_width <= cfg_data[15:0];
				REG_MIN_ADVANCE: scfg_q.min_advance <= cfg_data[15:0];
				REG_SWITCH_OFF_TIME: scfg_q.switch_off_time <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// timestamp extension: count a pending overflow when the capture is
	// from after the wrap (bit 15 clear)
	always_comb begin
		upper = in_q.extension_count;
		if (in_q.overflow_pending && !in_q.edge_time[15])
			upper = in_q.extension_count + 16'd1;
		stamp = {upper, in_q.edge_time};
	end

	// saturated rpm
	assign rpm = ((period_q == '0) || (quotient[DIV_W-1:16] != '0)) ? SAT_16 : quotient[15:0];

	assign launch = (state_q == ST_RUN);

	cers_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(launch),
		.dividend(tpm_q),
		.divisor(period_q),
		.done(div_done),
		.quotient(quotient)
	);

	cers_sched u_sched (
		.clk(clk),
		.arst_n(arst_n),
		.start(launch),
		.word(in_q),
		.stamp(stamp_q),
		.cfg(scfg_q),
		.res(sres)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q <= '0;
			teeth_q <= '0;
			out_valid_q <= 1'b0;
			leading_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXT;
				end
				ST_EXT: begin
					leading_q <= in_q.rising;
					if (in_q.rising) begin
						prev_q <= stamp;
						teeth_q <= teeth_q + 16'd1;
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RUN: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (div_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			in_q <= in_data;
		if (state_q == ST_EXT) begin
			stamp_q <= stamp;
			period_q <= stamp - prev_q;
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			if (leading_q) begin
				out_q.leading_edge <= 1'b1;
				out_q.full_timestamp <= stamp_q;
				out_q.pulse_period <= period_q;
				out_q.rpm <= rpm;
				out_q.action <= sres.action;
				out_q.start_time <= sres.start_time;
				out_q.teeth_seen <= teeth_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> src/cers_checker.sv
module cers_checker import cers_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_word_t out_data
);

	// one edge at a time: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accept");

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// falling edge gives an all-zero word
	a_falling_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.leading_edge |-> out_data == '0)
		else $error("falling edge word not zero");

	// zero period saturates rpm
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.leading_edge && out_data.pulse_period == '0
		|-> out_data.rpm == SAT_16)
		else $error("zero period without saturated rpm");

	// no injection means no start time
	a_no_inj: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.action == ACT_NONE |-> out_data.start_time == '0)
		else $error("start time set without injection");

endmodule

bind crank_edge_rpm_and_injection_scheduler cers_checker u_cers_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

>>> tb/crank_edge_rpm_and_injection_scheduler_tb.sv
`timescale 1ns / 100ps

module crank_edge_rpm_and_injection_scheduler_tb;
	import cers_pkg::*;

	// one edge waiting to be sent, optionally held back until all results are in
	typedef struct {
		in_word_t word;
		bit drain;
	} edge_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register shadows and block state as the predictor sees them
	logic [31:0] tpm_reg = TPM_RESET;
	logic [15:0] min_pw_reg = '0;
	logic [15:0] min_adv_reg = '0;
	logic [15:0] off_time_reg = '0;
	logic [31:0] prev_stamp = '0;
	logic [15:0] tooth_cnt = '0;

	edge_req_t pending_edges[$];
	out_word_t expected_results[$];
	int unsigned edges_in_flight = 0;
	int unsigned errors = 0;
	bit no_idle = 1'b0;
	int unsigned drv_gap = 0;
	int unsigned rdy_gap = 0;
	logic [31:0] crank_t = '0;

	int unsigned rising_sent = 0;
	int unsigned falling_sent = 0;
	int unsigned program_seen = 0;
	int unsigned hold_seen = 0;
	int unsigned settings_count = 0;

	crank_edge_rpm_and_injection_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// expected result of one edge; updates the tracked state on a rising edge
	function automatic out_word_t predict_edge_result(input in_word_t w);
		out_word_t r;
		logic [15:0] upper;
		logic [31:0] quo;
		logic [31:0] half;
		logic [31:0] max_after;
		logic [31:0] adv;
		logic [31:0] diff;
		r = '0;
		if (w.rising) begin
			tooth_cnt = tooth_cnt + 16'd1;
			upper = w.extension_count;
			// overflow counts only if the capture happened after the wrap
			if (w.overflow_pending && !w.edge_time[15])
				upper = upper + 16'd1;
			r.full_timestamp = {upper, w.edge_time};
			r.pulse_period = r.full_timestamp - prev_stamp;
			prev_stamp = r.full_timestamp;
			if (r.pulse_period == 32'd0) begin
				r.rpm = SAT_16;
			end else begin
				quo = tpm_reg / r.pulse_period;
				r.rpm = (quo > 32'h0000_FFFF) ? SAT_16 : quo[15:0];
			end
			if (w.pulse_width > min_pw_reg) begin
				half = w.cycle_period >> 1;
				max_after = (half > 32'h0000_FFFF) ? 32'h0000_FFFF : half;
				// upper bound wins over the lower one
				if ({16'd0, w.injection_angle} > max_after)
					adv = max_after;
				else if (w.injection_angle < min_adv_reg)
					adv = {16'd0, min_adv_reg};
				else
					adv = {16'd0, w.injection_angle};
				r.start_time = w.edge_time + adv[15:0];
				diff = (r.full_timestamp + adv) - (w.last_end_time + {16'd0, off_time_reg});
				r.action = (!w.channel_busy || diff > HALF_RANGE) ? ACT_PROGRAM : ACT_HOLD;
			end
			r.leading_edge = 1'b1;
			r.teeth_seen = tooth_cnt;
		end
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic in_word_t make_word(input logic [15:0] edge_time, input logic rising,
			input logic ovf, input logic [15:0] ext, input logic [15:0] pw,
			input logic [15:0] angle, input logic [31:0] cycle, input logic [31:0] last_end,
			input logic busy);
		in_word_t w;
		w.edge_time = edge_time;
		w.rising = rising;
		w.overflow_pending = ovf;
		w.extension_count = ext;
		w.pulse_width = pw;
		w.injection_angle = angle;
		w.cycle_period = cycle;
		w.last_end_time = last_end;
		w.channel_busy = busy;
		return w;
	endfunction

	task automatic queue_edge(input in_word_t w, input bit drain);
		edge_req_t e;
		e.word = w;
		e.drain = drain;
		pending_edges.push_back(e);
		edges_in_flight++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// register writes, only once every queued edge has its result
	task automatic program_settings(input logic [31:0] tpm, input logic [15:0] mpw,
			input logic [15:0] madv, input logic [15:0] sot);
		logic [CFG_IDX_W-1:0] junk_idx;
		while (edges_in_flight != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		junk_idx = $urandom_range(4, 255);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TICKS_PER_MINUTE;
		cfg_data <= tpm;
		@(posedge clk);
		cfg_index <= REG_MIN_PULSE_WIDTH;
		cfg_data <= {16'($urandom), mpw};
		@(posedge clk);
		cfg_index <= REG_MIN_ADVANCE;
		cfg_data <= {16'($urandom), madv};
		@(posedge clk);
		cfg_index <= REG_SWITCH_OFF_TIME;
		cfg_data <= {16'($urandom), sot};
		// unmapped index must leave everything alone
		@(posedge clk);
		cfg_index <= junk_idx;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		tpm_reg = tpm;
		min_pw_reg = mpw;
		min_adv_reg = madv;
		off_time_reg = sot;
		settings_count++;
	endtask

	// mostly plausible crank sequences, the rest noise and broken patterns
	task automatic queue_random_edges(input int unsigned count);
		int unsigned n;
		int unsigned r;
		logic [31:0] step;
		logic [31:0] mid;
		logic [15:0] ext;
		logic [15:0] pw;
		logic [31:0] cycle;
		logic [31:0] lend;
		logic ovf;
		in_word_t w;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 20) begin
				w.edge_time = $urandom;
				w.rising = $urandom;
				w.overflow_pending = $urandom;
				w.extension_count = $urandom;
				w.pulse_width = $urandom;
				w.injection_angle = $urandom;
				w.cycle_period = $urandom;
				w.last_end_time = $urandom;
				w.channel_busy = $urandom;
				queue_edge(w, $urandom_range(0, 99) < 2);
				n++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45)
					step = $urandom_range(1000, 60000);
				else if (r < 75)
					step = $urandom_range(60001, 3000000);
				else if (r < 85)
					step = $urandom_range(0, 40);
				else
					step = $urandom;
				mid = crank_t + (step >> 1);
				crank_t = crank_t + step;
				// falling edge between teeth, skipped now and then
				if ($urandom_range(0, 99) < 85) begin
					w = make_word(mid[15:0], 1'b0, $urandom, mid[31:16], $urandom, $urandom,
						$urandom, $urandom, $urandom);
					queue_edge(w, 1'b0);
					n++;
				end
				ovf = $urandom;
				ext = crank_t[31:16];
				if (ovf && !crank_t[15])
					ext = ext - 16'd1;
				r = $urandom_range(0, 99);
				if (r < 70 && min_pw_reg != 16'hFFFF)
					pw = $urandom_range(32'(min_pw_reg) + 1, 65535);
				else if (r < 85)
					pw = min_pw_reg;
				else
					pw = $urandom;
				r = $urandom_range(0, 99);
				if (r < 30)
					cycle = $urandom;
				else if (r < 70)
					cycle = $urandom_range(0, 32'h3FFFF);
				else
					cycle = $urandom_range(0, 32'h400);
				r = $urandom_range(0, 99);
				if (r < 40)
					lend = crank_t + $urandom_range(0, 32'h40000) - 32'h20000;
				else if (r < 70)
					lend = crank_t - HALF_RANGE + $urandom_range(0, 32'h30000) - 32'h18000;
				else
					lend = $urandom;
				w = make_word(crank_t[15:0], 1'b1, ovf, ext, pw, $urandom, cycle, lend,
					$urandom_range(0, 99) < 70);
				queue_edge(w, $urandom_range(0, 99) < 2);
				n++;
			end
		end
	endtask

	// driver: presents queued edges and records the expectation on accept
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_edge_result(in_data));
				if (in_data.rising)
					rising_sent++;
				else
					falling_sent++;
				drv_gap = idle_gap();
			end
			if (in_valid && !in_ready) begin
				// word still waiting, hold it
			end else if (drv_gap > 0) begin
				drv_gap--;
				in_valid <= 1'b0;
			end else if (pending_edges.size() > 0
					&& (!pending_edges[0].drain || expected_results.size() == 0)) begin
				in_valid <= 1'b1;
				in_data <= pending_edges[0].word;
				pending_edges.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result word against the oldest expectation
	always @(posedge clk) begin : collect_proc
		out_word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$error("result word with no edge outstanding: %h", out_data);
				end else begin
					want = expected_results.pop_front();
					check_field("leading_edge", want.leading_edge, out_data.leading_edge);
					check_field("full_timestamp", want.full_timestamp, out_data.full_timestamp);
					check_field("pulse_period", want.pulse_period, out_data.pulse_period);
					check_field("rpm", want.rpm, out_data.rpm);
					check_field("action", want.action, out_data.action);
					check_field("start_time", want.start_time, out_data.start_time);
					check_field("teeth_seen", want.teeth_seen, out_data.teeth_seen);
					if (want.action == ACT_PROGRAM)
						program_seen++;
					else if (want.action == ACT_HOLD)
						hold_seen++;
					if (edges_in_flight > 0)
						edges_in_flight--;
				end
				rdy_gap = idle_gap();
			end else if (!out_valid && rdy_gap == 0 && $urandom_range(0, 99) < 10) begin
				// stall ahead of the next word now and then
				rdy_gap = idle_gap();
			end
		end
		if (rdy_gap > 0) begin
			rdy_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [31:0] tpm;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: falling edge, zero stamp, overflow wrap, clamps, half-range test
		queue_edge(make_word(16'h1234, 1'b0, 1'b1, 16'hABCD, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0);
		queue_edge(make_word(16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h1234,
			32'h100, 32'h0, 1'b1), 1'b0);
		queue_edge(make_word(16'h0001, 1'b1, 1'b1, 16'hFFFF, 16'h0001, 16'hFFFF,
			32'hFFFF_FFFF, 32'h0, 1'b0), 1'b0);
		queue_edge(make_word(16'hFFFF, 1'b1, 1'b1, 16'h0012, 16'hFFFF, 16'd5000,
			32'd1000, 32'h0012_FFFF + 32'd500, 1'b1), 1'b1);
		queue_edge(make_word(16'h8000, 1'b1, 1'b0, 16'h4000, 16'h0800, 16'h0000,
			32'h0, 32'h4000_8000 - HALF_RANGE, 1'b1), 1'b0);
		queue_edge(make_word(16'h8000, 1'b1, 1'b0, 16'h4001, 16'h0800, 16'h0000,
			32'h0, 32'h4001_8000 - HALF_RANGE - 32'd1, 1'b1), 1'b0);
		queue_edge(make_word(16'h8000, 1'b1, 1'b0, 16'h4001, 16'h0800, 16'h0000,
			32'h0, 32'h0, 1'b0), 1'b0);

		// pulse width threshold, lower clamp, switch-off offset, inverted clamp bounds
		program_settings(32'hFFFF_FFFF, 16'd100, 16'd500, 16'h1234);
		queue_edge(make_word(16'h0100, 1'b1, 1'b0, 16'h0200, 16'd100, 16'd900,
			32'h20000, 32'h0, 1'b1), 1'b0);
		queue_edge(make_word(16'h0100, 1'b1, 1'b0, 16'h0201, 16'd101, 16'd10,
			32'h20000, 32'h0, 1'b0), 1'b0);
		queue_edge(make_word(16'h0100, 1'b1, 1'b0, 16'h0203, 16'hFFFF, 16'd800,
			32'h20000, 32'h0203_0100 + 32'd800 - 32'h1234, 1'b1), 1'b0);
		queue_edge(make_word(16'h0100, 1'b1, 1'b0, 16'h0204, 16'hFFFF, 16'd400,
			32'd600, 32'h0, 1'b0), 1'b0);
		queue_edge(make_word(16'h0100, 1'b1, 1'b0, 16'h0205, 16'hFFFF, 16'd200,
			32'd601, 32'h0, 1'b1), 1'b0);
		queue_edge(make_word(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0);
		queue_edge(make_word(16'h7FFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), 1'b0);

		// random phases over several register settings
		for (int p = 0; p < 6; p++) begin
			tpm = $urandom_range(32'hFFFF_FFFF, 1);
			no_idle = (p == 1);
			case (p)
				0: program_settings(TPM_RESET, $urandom, $urandom_range(0, 3000), $urandom);
				1: program_settings(32'd1, 16'h0000, 16'h0000, 16'h0000);
				2: program_settings(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				5: program_settings(TPM_RESET, 16'h0000, $urandom_range(0, 2000),
					$urandom_range(0, 2000));
				default: program_settings(tpm, $urandom, $urandom, $urandom);
			endcase
			queue_random_edges((p == 2) ? 120 : 156);
		end

		while (edges_in_flight != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Covered %0d rising and %0d falling edges over %0d register settings.",
			rising_sent, falling_sent, settings_count);
		$display("Injection results: %0d program-now, %0d hold; %0d mismatches.",
			program_seen, hold_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
